>>> src/ptsa_pkg.sv
// shared types and constants for the priority task scheduler
package ptsa_pkg;

  // event codes
  localparam logic [2:0] MODE_TICK     = 3'd0;
  localparam logic [2:0] MODE_DELAY    = 3'd1;
  localparam logic [2:0] MODE_SUSPEND  = 3'd2;
  localparam logic [2:0] MODE_ACTIVATE = 3'd3;
  localparam logic [2:0] MODE_CREATE   = 3'd4;
  localparam logic [2:0] MODE_DISABLE  = 3'd5;
  localparam logic [2:0] MODE_ENABLE   = 3'd6;
  localparam logic [2:0] MODE_WAKE     = 3'd7;

  // task status codes
  localparam logic [1:0] ST_READY     = 2'd0;
  localparam logic [1:0] ST_RUNNING   = 2'd1;
  localparam logic [1:0] ST_WAITING   = 2'd2;
  localparam logic [1:0] ST_SUSPENDED = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_TASK_COUNT = 2'd0;
  localparam logic [1:0] CFG_PRIORITIES = 2'd1;
  localparam logic [1:0] CFG_AUTOSTART  = 2'd2;

  // one alarm table entry
  typedef struct packed {
    logic [31:0] period;
    logic [31:0] remaining;
    logic [2:0]  target;
    logic        periodic;
  } alarm_entry_t;

endpackage

>>> src/priority_task_scheduler_with_alarms.sv
// priority task scheduler top level: sequencer over task and alarm memories
//
//  channel  ports                                   transfer when
//  in       in_mode in_task_id in_count_ticks ...   start && !busy
//  out      out_running_task out_switched ...       out_valid
//  cfg      cfg_we cfg_index cfg_wdata              cfg_we
//
// a tick keeps busy high through an event step, one read-modify-write sweep over each
// memory that holds entries, a one-task-a-cycle priority scan that includes the idle
// task, a commit and a done step; the result strobes in the next cycle, when a new item
// may be taken. other scheduling events skip the sweeps; alarm events go from the event
// step straight to done. the first item after reset first loads the delay memory and
// the task status and schedules once. reset clears control state; memory contents
// need no reset.
// the result strobes for one cycle; the receiver cannot stall it.
module priority_task_scheduler_with_alarms #(
  parameter int unsigned MAX_TASKS  = 8,
  parameter int unsigned MAX_ALARMS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_mode,
  input  logic [2:0]  in_task_id,
  input  logic [31:0] in_count_ticks,
  input  logic [2:0]  in_alarm_id,
  input  logic        in_alarm_repeats,
  input  logic        in_alarm_starts_enabled,
  output logic        out_valid,
  output logic [3:0]  out_running_task,
  output logic        out_switched,
  output logic [31:0] out_tick_count,
  output logic [2:0]  out_alarm_handle,
  output logic        out_create_failed,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_wdata
);

  localparam int unsigned NT  = MAX_TASKS + 1;
  localparam int unsigned TW  = $clog2(NT);
  localparam int unsigned AW  = (MAX_ALARMS > 1) ? $clog2(MAX_ALARMS) : 1;
  localparam int unsigned ACW = $clog2(MAX_ALARMS + 1);

  // sequencer states
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_INIT   = 4'd1;
  localparam logic [3:0] S_EVENT  = 4'd2;
  localparam logic [3:0] S_TRD    = 4'd3;
  localparam logic [3:0] S_TWR    = 4'd4;
  localparam logic [3:0] S_ARD    = 4'd5;
  localparam logic [3:0] S_AWR    = 4'd6;
  localparam logic [3:0] S_SCAN   = 4'd7;
  localparam logic [3:0] S_COMMIT = 4'd8;
  localparam logic [3:0] S_DONE   = 4'd9;

  logic [3:0]  state_r, state_nxt;

  // configuration registers
  logic [3:0]  task_count_r;
  logic [63:0] prio_r;
  logic [7:0]  auto_r;

  // scheduler state
  logic [1:0]  status_r [NT];
  logic [MAX_ALARMS-1:0] aen_r;
  logic [TW:0] live_r;
  logic [TW:0] cur_r;
  logic        started_r;
  logic [31:0] ticks_r;
  logic [ACW-1:0] used_r;

  // latched item
  logic [2:0]  mode_r;
  logic [2:0]  tid_r;
  logic [31:0] cnt_r;
  logic [2:0]  aid_r;
  logic        rep_r;
  logic        en_r;

  // sweep and scan bookkeeping
  logic [TW:0]   idx_r;
  logic [ACW-1:0] aidx_r;
  logic [TW:0]   best_r;
  logic [8:0]    top_r;
  logic          sw_r;
  logic [2:0]    handle_r;
  logic          failed_r;
  logic          resched_r;

  // memories
  logic         wm_we;
  logic [TW-1:0] wm_waddr, wm_raddr;
  logic [31:0]  wm_wdata, wm_rdata;
  logic         am_we;
  logic [AW-1:0] am_waddr, am_raddr;
  ptsa_pkg::alarm_entry_t am_wdata, am_rdata;

  ptsa_wait_mem #(.DEPTH(NT), .AW(TW)) u_wait (
    .clk(clk), .wr_en(wm_we), .wr_addr(wm_waddr), .wr_data(wm_wdata),
    .rd_addr(wm_raddr), .rd_data(wm_rdata)
  );

  ptsa_alarm_mem #(.DEPTH(MAX_ALARMS), .AW(AW)) u_alarm (
    .clk(clk), .wr_en(am_we), .wr_addr(am_waddr), .wr_data(am_wdata),
    .rd_addr(am_raddr), .rd_data(am_rdata)
  );

  logic [31:0] cnt_fix;
  assign cnt_fix = (in_count_ticks == 32'd0) ? 32'd1 : in_count_ticks;

  assign busy = (state_r != S_IDLE);

  // priority of a task index, zero for the idle task and beyond
  function automatic logic [7:0] prio_of(input logic [TW:0] i, input logic [TW:0] live,
                                         input logic [63:0] p);
    logic [7:0] r;
    r = 8'd0;
    for (int k = 0; k < 8; k++) begin
      if (i == (TW+1)'(k) && i < live) r = p[8*k +: 8];
    end
    return r;
  endfunction

  // counts down the memory entries
  logic [31:0] wdec, adec;
  assign wdec = wm_rdata - 32'd1;
  assign adec = am_rdata.remaining - 32'd1;

  // memory port control
  always_comb begin
    wm_we    = 1'b0;
    wm_waddr = idx_r[TW-1:0];
    wm_wdata = 32'd0;
    wm_raddr = idx_r[TW-1:0];
    am_we    = 1'b0;
    am_waddr = aidx_r[AW-1:0];
    am_wdata = am_rdata;
    am_raddr = aidx_r[AW-1:0];
    unique case (state_r)
      S_INIT: begin
        wm_we = 1'b1;
      end
      S_EVENT: begin
        if (mode_r == ptsa_pkg::MODE_DELAY && cur_r < live_r) begin
          wm_we    = 1'b1;
          wm_waddr = cur_r[TW-1:0];
          wm_wdata = cnt_r;
        end
        if (mode_r == ptsa_pkg::MODE_CREATE && used_r < ACW'(MAX_ALARMS)) begin
          am_we    = 1'b1;
          am_waddr = used_r[AW-1:0];
          am_wdata = '{period: cnt_r, remaining: cnt_r, target: tid_r, periodic: rep_r};
        end
      end
      S_TWR: begin
        if (status_r[idx_r[TW-1:0]] == ptsa_pkg::ST_WAITING) begin
          wm_we    = 1'b1;
          wm_wdata = wdec;
        end
      end
      S_AWR: begin
        if (aen_r[aidx_r[AW-1:0]]) begin
          am_we = 1'b1;
          am_wdata.remaining = (adec == 32'd0) ? am_rdata.period : adec;
        end
      end
      default: begin
      end
    endcase
  end

  logic [7:0] scan_p;
  assign scan_p = prio_of(idx_r, live_r, prio_r);

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (start) state_nxt = started_r ? S_EVENT : S_INIT;
      S_INIT:   if (idx_r == live_r) state_nxt = S_SCAN;
      S_EVENT: begin
        if (mode_r == ptsa_pkg::MODE_TICK) begin
          if (live_r != '0) state_nxt = S_TRD;
          else if (used_r != '0) state_nxt = S_ARD;
          else state_nxt = S_SCAN;
        end else if (mode_r == ptsa_pkg::MODE_DELAY || mode_r == ptsa_pkg::MODE_SUSPEND ||
                     mode_r == ptsa_pkg::MODE_ACTIVATE || mode_r == ptsa_pkg::MODE_WAKE)
          state_nxt = S_SCAN;
        else state_nxt = S_DONE;
      end
      S_TRD:    state_nxt = S_TWR;
      S_TWR: begin
        if (idx_r + 1'b1 >= live_r) state_nxt = (used_r == '0) ? S_SCAN : S_ARD;
        else state_nxt = S_TRD;
      end
      S_ARD:    state_nxt = S_AWR;
      S_AWR:    state_nxt = (aidx_r + 1'b1 >= used_r) ? S_SCAN : S_ARD;
      S_SCAN:   if (idx_r == live_r) state_nxt = S_COMMIT;
      S_COMMIT: state_nxt = resched_r ? S_EVENT : S_DONE;
      S_DONE:   state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      task_count_r <= 4'd0;
      prio_r       <= 64'd0;
      auto_r       <= 8'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ptsa_pkg::CFG_TASK_COUNT: task_count_r <= cfg_wdata[3:0];
        ptsa_pkg::CFG_PRIORITIES: prio_r <= cfg_wdata;
        ptsa_pkg::CFG_AUTOSTART:  auto_r <= cfg_wdata[7:0];
        default: begin
        end
      endcase
    end
  end

  // sequencer registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      started_r <= 1'b0;
      ticks_r   <= 32'd0;
      used_r    <= '0;
      aen_r     <= '0;
      live_r    <= '0;
      cur_r     <= '0;
      idx_r     <= '0;
      aidx_r    <= '0;
      out_valid <= 1'b0;
      resched_r <= 1'b0;
      for (int k = 0; k < NT; k++) status_r[k] <= ptsa_pkg::ST_READY;
    end else begin
      state_r   <= state_nxt;
      out_valid <= (state_r == S_DONE);
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            mode_r   <= in_mode;
            tid_r    <= in_task_id;
            cnt_r    <= cnt_fix;
            aid_r    <= in_alarm_id;
            rep_r    <= in_alarm_repeats;
            en_r     <= in_alarm_starts_enabled;
            sw_r     <= 1'b0;
            handle_r <= 3'd0;
            failed_r <= 1'b0;
            idx_r    <= '0;
            aidx_r   <= '0;
            if (!started_r) begin
              live_r <= (task_count_r > 4'(MAX_TASKS)) ? (TW+1)'(MAX_TASKS)
                                                      : (TW+1)'(task_count_r);
            end
          end
        end
        S_INIT: begin
          // load status from the autostart mask, one delay entry a cycle
          if (idx_r == live_r) begin
            status_r[idx_r[TW-1:0]] <= ptsa_pkg::ST_READY;
            cur_r     <= live_r + 1'b1;
            started_r <= 1'b1;
            resched_r <= 1'b1;
            idx_r     <= '0;
            top_r     <= 9'h1ff;
            best_r    <= live_r;
          end else begin
            status_r[idx_r[TW-1:0]] <= (idx_r < (TW+1)'(8) && auto_r[idx_r[2:0]])
                                       ? ptsa_pkg::ST_READY : ptsa_pkg::ST_SUSPENDED;
            idx_r <= idx_r + 1'b1;
          end
        end
        S_EVENT: begin
          idx_r  <= '0;
          aidx_r <= '0;
          top_r  <= 9'h1ff;
          best_r <= live_r;
          unique case (mode_r)
            ptsa_pkg::MODE_TICK: begin
              ticks_r <= ticks_r + 32'd1;
            end
            ptsa_pkg::MODE_DELAY: begin
              if (cur_r < live_r) status_r[cur_r[TW-1:0]] <= ptsa_pkg::ST_WAITING;
            end
            ptsa_pkg::MODE_SUSPEND: begin
              if (cur_r < live_r) status_r[cur_r[TW-1:0]] <= ptsa_pkg::ST_SUSPENDED;
            end
            ptsa_pkg::MODE_ACTIVATE, ptsa_pkg::MODE_WAKE: begin
              if ((TW+1)'(tid_r) < live_r) status_r[TW'(tid_r)] <= ptsa_pkg::ST_READY;
            end
            ptsa_pkg::MODE_CREATE: begin
              if (used_r >= ACW'(MAX_ALARMS)) begin
                failed_r <= 1'b1;
              end else begin
                aen_r[used_r[AW-1:0]] <= en_r;
                handle_r <= 3'(used_r);
                used_r   <= used_r + 1'b1;
              end
            end
            ptsa_pkg::MODE_DISABLE: begin
              if (ACW'(aid_r) < used_r) aen_r[aid_r[AW-1:0]] <= 1'b0;
            end
            ptsa_pkg::MODE_ENABLE: begin
              if (ACW'(aid_r) < used_r) aen_r[aid_r[AW-1:0]] <= 1'b1;
            end
            default: begin
            end
          endcase
        end
        S_TRD: begin
        end
        S_TWR: begin
          if (status_r[idx_r[TW-1:0]] == ptsa_pkg::ST_WAITING && wdec == 32'd0)
            status_r[idx_r[TW-1:0]] <= ptsa_pkg::ST_READY;
          if (idx_r + 1'b1 >= live_r) idx_r <= '0;
          else idx_r <= idx_r + 1'b1;
        end
        S_ARD: begin
        end
        S_AWR: begin
          if (aen_r[aidx_r[AW-1:0]] && adec == 32'd0) begin
            if ((TW+1)'(am_rdata.target) < live_r)
              status_r[TW'(am_rdata.target)] <= ptsa_pkg::ST_READY;
            if (!am_rdata.periodic) aen_r[aidx_r[AW-1:0]] <= 1'b0;
          end
          aidx_r <= aidx_r + 1'b1;
        end
        S_SCAN: begin
          // one task a cycle, strict compare keeps the lowest index on a tie
          if (status_r[idx_r[TW-1:0]] == ptsa_pkg::ST_READY ||
              status_r[idx_r[TW-1:0]] == ptsa_pkg::ST_RUNNING) begin
            if (top_r == 9'h1ff || {1'b0, scan_p} > top_r) begin
              top_r  <= {1'b0, scan_p};
              best_r <= idx_r;
            end
          end
          if (idx_r != live_r) idx_r <= idx_r + 1'b1;
        end
        S_COMMIT: begin
          if (best_r != cur_r) begin
            if (cur_r <= live_r && status_r[cur_r[TW-1:0]] == ptsa_pkg::ST_RUNNING)
              status_r[cur_r[TW-1:0]] <= ptsa_pkg::ST_READY;
            cur_r <= best_r;
          end
          status_r[best_r[TW-1:0]] <= ptsa_pkg::ST_RUNNING;
          if (best_r != cur_r || resched_r) sw_r <= 1'b1;
          resched_r <= 1'b0;
        end
        S_DONE: begin
        end
        default: begin
        end
      endcase
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (state_r == S_DONE) begin
      out_running_task  <= 4'(cur_r);
      out_switched      <= sw_r;
      out_tick_count    <= ticks_r;
      out_alarm_handle  <= handle_r;
      out_create_failed <= failed_r;
    end
  end

  // checks
  a_valid_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than one cycle");
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("item not taken");
  a_fail_no_handle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_create_failed) |-> out_alarm_handle == 3'd0)
    else $error("failed create gave a handle");
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= ACW'(MAX_ALARMS)) else $error("alarm count overflow");

endmodule

>>> src/ptsa_alarm_mem.sv
// alarm table memory: one write port, one registered read port
module ptsa_alarm_mem #(
  parameter int unsigned DEPTH = 8,
  parameter int unsigned AW    = 3
) (
  input  logic                  clk,
  input  logic                  wr_en,
  input  logic [AW-1:0]         wr_addr,
  input  ptsa_pkg::alarm_entry_t wr_data,
  input  logic [AW-1:0]         rd_addr,
  output ptsa_pkg::alarm_entry_t rd_data
);

  ptsa_pkg::alarm_entry_t mem [DEPTH];

  // write
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

>>> src/ptsa_wait_mem.sv
// task delay count memory: one write port, one registered read port
module ptsa_wait_mem #(
  parameter int unsigned DEPTH = 9,
  parameter int unsigned AW    = 4
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [31:0]   wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [31:0]   rd_data
);

  logic [31:0] mem [DEPTH];

  // write
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

>>> test/priority_task_scheduler_with_alarms_test.sv
// testbench for the priority task scheduler: directed and random events, self-checking
`timescale 1ns / 1ps

module priority_task_scheduler_with_alarms_test;

  localparam int unsigned NUM_TASKS  = 8;
  localparam int unsigned NUM_ALARMS = 8;
  localparam int unsigned DRAIN_CYCLES = 80;
  localparam longint unsigned CYCLE_LIMIT = 800000;

  typedef struct packed {
    logic [3:0]  running_task;
    logic        switched;
    logic [31:0] tick_count;
    logic [2:0]  alarm_handle;
    logic        create_failed;
  } sched_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  in_mode = ptsa_pkg::MODE_TICK;
  logic [2:0]  in_task_id = '0;
  logic [31:0] in_count_ticks = '0;
  logic [2:0]  in_alarm_id = '0;
  logic        in_alarm_repeats = 1'b0;
  logic        in_alarm_starts_enabled = 1'b0;
  logic        out_valid;
  logic [3:0]  out_running_task;
  logic        out_switched;
  logic [31:0] out_tick_count;
  logic [2:0]  out_alarm_handle;
  logic        out_create_failed;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = ptsa_pkg::CFG_TASK_COUNT;
  logic [63:0] cfg_wdata = '0;

  priority_task_scheduler_with_alarms dut (.*);

  always #1 clk = ~clk;

  // shadow copies of the configuration
  logic [3:0]  sh_task_count = '0;
  logic [63:0] sh_priorities = '0;
  logic [7:0]  sh_autostart = '0;

  // scheduler state as predicted
  logic [1:0]  task_state [NUM_TASKS+1];
  logic [31:0] task_delay [NUM_TASKS+1];
  int unsigned cur_task;
  bit          sched_started;
  logic [31:0] ticks;
  int unsigned alarms_made;
  logic [31:0] alm_period [NUM_ALARMS];
  logic [31:0] alm_left [NUM_ALARMS];
  logic [2:0]  alm_target [NUM_ALARMS];
  bit          alm_on [NUM_ALARMS];
  bit          alm_repeat [NUM_ALARMS];
  int unsigned live;

  sched_result_t pending_results[$];
  int unsigned errors = 0;
  int unsigned events_sent = 0;
  int unsigned results_seen = 0;
  longint unsigned cycles = 0;

  initial begin
    for (int i = 0; i <= NUM_TASKS; i++) begin
      task_state[i] = ptsa_pkg::ST_READY;
      task_delay[i] = '0;
    end
    for (int i = 0; i < NUM_ALARMS; i++) alm_on[i] = 0;
    cur_task = 0;
    sched_started = 0;
    ticks = '0;
    alarms_made = 0;
    live = 0;
  end

  function automatic int unsigned task_prio(int unsigned i);
    if (i >= live || i >= 8) return 0;
    return 32'(sh_priorities[8*i +: 8]);
  endfunction

  function automatic void wake_task(int unsigned t);
    if (t < live) task_state[t] = ptsa_pkg::ST_READY;
  endfunction

  // pick the highest priority ready task, lowest index on a tie
  function automatic bit pick_task();
    int unsigned best;
    int top;
    best = live;
    top = -1;
    for (int unsigned i = 0; i <= live; i++) begin
      if (task_state[i] == ptsa_pkg::ST_READY || task_state[i] == ptsa_pkg::ST_RUNNING) begin
        if (int'(task_prio(i)) > top) begin
          top = int'(task_prio(i));
          best = i;
        end
      end
    end
    if (best != cur_task) begin
      if (cur_task <= live && task_state[cur_task] == ptsa_pkg::ST_RUNNING)
        task_state[cur_task] = ptsa_pkg::ST_READY;
      cur_task = best;
      task_state[best] = ptsa_pkg::ST_RUNNING;
      return 1;
    end
    task_state[best] = ptsa_pkg::ST_RUNNING;
    return 0;
  endfunction

  function automatic sched_result_t schedule_event(logic [2:0] mode, logic [2:0] tid,
                                                   logic [31:0] cnt, logic [2:0] aid,
                                                   logic rep, logic en);
    sched_result_t r;
    bit sw;
    int unsigned n;
    sw = 0;
    r = '0;
    if (cnt == 0) cnt = 1;
    // first event loads the task table
    if (!sched_started) begin
      n = (sh_task_count > NUM_TASKS) ? NUM_TASKS : sh_task_count;
      live = n;
      for (int unsigned i = 0; i < n; i++) begin
        task_state[i] = sh_autostart[i] ? ptsa_pkg::ST_READY : ptsa_pkg::ST_SUSPENDED;
        task_delay[i] = '0;
      end
      task_state[n] = ptsa_pkg::ST_READY;
      task_delay[n] = '0;
      cur_task = n + 1;
      sched_started = 1;
      void'(pick_task());
      sw = 1;
    end
    case (mode)
      ptsa_pkg::MODE_TICK: begin
        ticks++;
        for (int unsigned i = 0; i < live; i++) begin
          if (task_state[i] == ptsa_pkg::ST_WAITING) begin
            task_delay[i]--;
            if (task_delay[i] == 0) task_state[i] = ptsa_pkg::ST_READY;
          end
        end
        for (int unsigned i = 0; i < alarms_made; i++) begin
          if (alm_on[i]) begin
            alm_left[i]--;
            if (alm_left[i] == 0) begin
              wake_task(alm_target[i]);
              alm_left[i] = alm_period[i];
              if (!alm_repeat[i]) alm_on[i] = 0;
            end
          end
        end
        sw |= pick_task();
      end
      ptsa_pkg::MODE_DELAY: begin
        if (cur_task < live) begin
          task_state[cur_task] = ptsa_pkg::ST_WAITING;
          task_delay[cur_task] = cnt;
        end
        sw |= pick_task();
      end
      ptsa_pkg::MODE_SUSPEND: begin
        if (cur_task < live) task_state[cur_task] = ptsa_pkg::ST_SUSPENDED;
        sw |= pick_task();
      end
      ptsa_pkg::MODE_ACTIVATE, ptsa_pkg::MODE_WAKE: begin
        wake_task(tid);
        sw |= pick_task();
      end
      ptsa_pkg::MODE_CREATE: begin
        if (alarms_made >= NUM_ALARMS) begin
          r.create_failed = 1'b1;
        end else begin
          alm_period[alarms_made] = cnt;
          alm_left[alarms_made] = cnt;
          alm_target[alarms_made] = tid;
          alm_repeat[alarms_made] = rep;
          alm_on[alarms_made] = en;
          r.alarm_handle = alarms_made[2:0];
          alarms_made++;
        end
      end
      ptsa_pkg::MODE_DISABLE: if (aid < alarms_made) alm_on[aid] = 0;
      default: if (aid < alarms_made) alm_on[aid] = 1;
    endcase
    r.running_task = cur_task[3:0];
    r.switched = sw;
    r.tick_count = ticks;
    return r;
  endfunction

  // one event transfer, after a random gap
  task automatic send_event(logic [2:0] mode, logic [2:0] tid, logic [31:0] cnt,
                            logic [2:0] aid, logic rep, logic en, bit no_gap = 0);
    int unsigned gap;
    bit taken;
    gap = no_gap ? 0 : ($urandom_range(0, 3) == 0 ? $urandom_range(0, 13) : 0);
    repeat (gap) begin
      start = 1'b0;
      @(negedge clk);
    end
    in_mode = mode;
    in_task_id = tid;
    in_count_ticks = cnt;
    in_alarm_id = aid;
    in_alarm_repeats = rep;
    in_alarm_starts_enabled = en;
    start = 1'b1;
    taken = 0;
    while (!taken) begin
      @(posedge clk);
      if (!busy) begin
        taken = 1;
        pending_results.push_back(schedule_event(mode, tid, cnt, aid, rep, en));
        events_sent++;
      end
    end
    @(negedge clk);
  endtask

  // wait for the block to drain, then settle
  task automatic wait_drained();
    start = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [63:0] value);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      ptsa_pkg::CFG_TASK_COUNT: sh_task_count = value[3:0];
      ptsa_pkg::CFG_PRIORITIES: sh_priorities = value;
      default: sh_autostart = value[7:0];
    endcase
  endtask

  // mostly short counts, sometimes any value
  function automatic logic [31:0] draw_count();
    if ($urandom_range(0, 19) == 0) return $urandom;
    return $urandom_range(0, 5);
  endfunction

  task automatic test_directed_events();
    send_event(ptsa_pkg::MODE_TICK, 3'd0, 32'd0, 3'd0, 1'b0, 1'b0, 1);
    send_event(ptsa_pkg::MODE_DELAY, 3'd0, 32'd0, 3'd0, 1'b0, 1'b0);
    send_event(ptsa_pkg::MODE_DELAY, 3'd0, 32'hFFFF_FFFF, 3'd0, 1'b0, 1'b0);
    send_event(ptsa_pkg::MODE_SUSPEND, 3'd0, 32'd0, 3'd0, 1'b0, 1'b0);
    send_event(ptsa_pkg::MODE_ENABLE, 3'd0, 32'd0, 3'd7, 1'b0, 1'b0);
    send_event(ptsa_pkg::MODE_DISABLE, 3'd0, 32'd0, 3'd0, 1'b0, 1'b0);
    send_event(ptsa_pkg::MODE_CREATE, 3'd1, 32'd0, 3'd0, 1'b1, 1'b1);
    send_event(ptsa_pkg::MODE_CREATE, 3'd7, 32'd2, 3'd0, 1'b0, 1'b1);
    send_event(ptsa_pkg::MODE_CREATE, 3'd2, 32'hFFFF_FFFF, 3'd0, 1'b0, 1'b0);
    send_event(ptsa_pkg::MODE_TICK, 3'd0, 32'd0, 3'd0, 1'b0, 1'b0);
    send_event(ptsa_pkg::MODE_TICK, 3'd0, 32'd0, 3'd0, 1'b0, 1'b0);
    send_event(ptsa_pkg::MODE_ACTIVATE, 3'd7, 32'd0, 3'd0, 1'b0, 1'b0);
    send_event(ptsa_pkg::MODE_ACTIVATE, 3'd6, 32'd0, 3'd0, 1'b0, 1'b0);
    send_event(ptsa_pkg::MODE_WAKE, 3'd3, 32'd0, 3'd0, 1'b0, 1'b0);
    send_event(ptsa_pkg::MODE_WAKE, 3'd0, 32'd0, 3'd0, 1'b0, 1'b0);
    send_event(ptsa_pkg::MODE_ENABLE, 3'd0, 32'd0, 3'd2, 1'b0, 1'b0);
    send_event(ptsa_pkg::MODE_DISABLE, 3'd0, 32'd0, 3'd0, 1'b0, 1'b0);
    // suspend everything so the idle task runs, then poke it
    repeat (6) send_event(ptsa_pkg::MODE_SUSPEND, 3'd0, 32'd0, 3'd0, 1'b0, 1'b0);
    send_event(ptsa_pkg::MODE_DELAY, 3'd0, 32'd4, 3'd0, 1'b0, 1'b0);
    send_event(ptsa_pkg::MODE_TICK, 3'd0, 32'd0, 3'd0, 1'b0, 1'b0);
    send_event(ptsa_pkg::MODE_WAKE, 3'd5, 32'd0, 3'd0, 1'b0, 1'b0);
  endtask

  task automatic test_random_events(int unsigned count);
    int unsigned pick;
    logic [2:0] mode;
    for (int unsigned k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) mode = ptsa_pkg::MODE_TICK;
      else if (pick < 42) mode = ptsa_pkg::MODE_DELAY;
      else if (pick < 50) mode = ptsa_pkg::MODE_SUSPEND;
      else if (pick < 65) mode = ptsa_pkg::MODE_ACTIVATE;
      else if (pick < 75) mode = ptsa_pkg::MODE_WAKE;
      else if (pick < 80) mode = ptsa_pkg::MODE_CREATE;
      else if (pick < 90) mode = ptsa_pkg::MODE_ENABLE;
      else mode = ptsa_pkg::MODE_DISABLE;
      send_event(mode, 3'($urandom_range(0, 7)), draw_count(), 3'($urandom_range(0, 7)),
                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                 ($urandom_range(0, 7) == 0));
    end
  endtask

  // result checker
  always @(posedge clk) begin
    sched_result_t exp_r;
    if (rst_n && out_valid) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result with no event outstanding");
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_running_task !== exp_r.running_task) begin
          $error("running_task expected %0d got %0d", exp_r.running_task, out_running_task);
          errors++;
        end
        if (out_switched !== exp_r.switched) begin
          $error("switched expected %0d got %0d", exp_r.switched, out_switched);
          errors++;
        end
        if (out_tick_count !== exp_r.tick_count) begin
          $error("tick_count expected %0d got %0d", exp_r.tick_count, out_tick_count);
          errors++;
        end
        if (out_alarm_handle !== exp_r.alarm_handle) begin
          $error("alarm_handle expected %0d got %0d", exp_r.alarm_handle, out_alarm_handle);
          errors++;
        end
        if (out_create_failed !== exp_r.create_failed) begin
          $error("create_failed expected %0d got %0d", exp_r.create_failed,
                 out_create_failed);
          errors++;
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    repeat (9) @(negedge clk);
    rst_n = 1'b1;
    // task count above the maximum first, then the one that is latched
    write_reg(ptsa_pkg::CFG_TASK_COUNT, 64'd15);
    write_reg(ptsa_pkg::CFG_TASK_COUNT, 64'd6);
    write_reg(ptsa_pkg::CFG_AUTOSTART, 64'hA5);
    write_reg(ptsa_pkg::CFG_PRIORITIES, 64'h0000_0A0A_0305_0A01);
    test_directed_events();
    wait_drained();
    // all priorities equal at zero, the idle task loses every tie
    write_reg(ptsa_pkg::CFG_PRIORITIES, 64'd0);
    write_reg(ptsa_pkg::CFG_TASK_COUNT, 64'd0);
    test_random_events(470);
    wait_drained();
    write_reg(ptsa_pkg::CFG_PRIORITIES, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(ptsa_pkg::CFG_AUTOSTART, 64'hFF);
    test_random_events(470);
    wait_drained();
    write_reg(ptsa_pkg::CFG_PRIORITIES, {$urandom, $urandom});
    write_reg(ptsa_pkg::CFG_TASK_COUNT, 64'd8);
    test_random_events(470);
    wait_drained();
    write_reg(ptsa_pkg::CFG_PRIORITIES, 64'h0102_0304_0506_0708);
    write_reg(ptsa_pkg::CFG_AUTOSTART, 64'h00);
    test_random_events(470);
    wait_drained();
    $display("covered %0d events and %0d results over %0d cycles", events_sent,
             results_seen, cycles);
    $display("five priority settings, alarm table filled, idle and unknown tasks hit");
    if (errors == 0 && pending_results.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

>>> sim.f
src/ptsa_pkg.sv
src/ptsa_alarm_mem.sv
src/ptsa_wait_mem.sv
src/priority_task_scheduler_with_alarms.sv
test/priority_task_scheduler_with_alarms_test.sv
